// File: rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent sequence must follow.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

`endif

// File: rtl/tlfd_pkg.sv
// Package for the type-length frame deframer: sizes, controller states and
// the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package tlfd_pkg;

  localparam int FRAME_STORE_BYTES = 64;
  localparam int HEADER_BYTES      = 2;
  localparam int BYTE_W            = 8;
  localparam int FIELD_W           = 6;
  localparam int ADDR_W            = $clog2(FRAME_STORE_BYTES);
  localparam int CNT_W             = $clog2(FRAME_STORE_BYTES + 1);
  localparam int TOT_W             = BYTE_W + 1;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_FETCH,
    ST_PRESENT
  } ctrl_state_t;

  typedef struct packed {
    logic take_byte;     // store the accepted byte and update the fill count
    logic start_replay;  // reset the replay index for a frame with payload
    logic load_empty;    // set up the single result of an empty frame
    logic fetch;         // read the store at the replay index
    logic advance;       // step the replay index
  } dp_cmd_t;

  typedef struct packed {
    logic empty_done;    // the incoming length byte closes an empty frame
    logic pay_done;      // the incoming byte is the last payload byte
    logic idx_last;      // the presented result ends the frame
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/tlfd_if.sv
// Valid/ready channel interfaces for the deframer's input and result requests.
// Depends on tlfd_pkg for field widths.
`default_nettype none

interface tlfd_in_if import tlfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tlfd_out_if import tlfd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  frame_command;
  logic [FIELD_W-1:0] payload_length;
  logic [FIELD_W-1:0] payload_index;
  logic [BYTE_W-1:0]  payload_byte;
  logic               has_payload;
  logic               frame_last;

  modport source (output valid, output frame_command, output payload_length,
                  output payload_index, output payload_byte, output has_payload,
                  output frame_last, input ready);
  modport sink   (input valid, input frame_command, input payload_length,
                  input payload_index, input payload_byte, input has_payload,
                  input frame_last, output ready);
endinterface

`default_nettype wire

// File: rtl/tlfd_dp.sv
// Datapath of the deframer: header registers, fill count, payload store,
// replay index and the registered read byte. Depends on tlfd_pkg.
`default_nettype none

module tlfd_dp import tlfd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [BYTE_W-1:0]  rx_byte,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  output logic [BYTE_W-1:0]       frame_command,
  output logic [FIELD_W-1:0]      payload_length,
  output logic [FIELD_W-1:0]      payload_index,
  output logic [BYTE_W-1:0]       payload_byte,
  output logic                    has_payload
);

  logic [BYTE_W-1:0] mem [FRAME_STORE_BYTES];

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0] cmd_r, len_r;
  logic [ADDR_W-1:0] idx_r;
  logic [BYTE_W-1:0] rdata_r;
  logic              has_payload_r;

  logic              cnt_is_cmd, cnt_is_len;
  logic              oversize;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;

  assign cnt_is_cmd = (count_r == CNT_W'(0));
  assign cnt_is_len = (count_r == CNT_W'(1));
  assign oversize   = cnt_is_len &&
                      ((TOT_W'(rx_byte) + TOT_W'(HEADER_BYTES)) > TOT_W'(FRAME_STORE_BYTES));

  assign stat.empty_done = cnt_is_len && (rx_byte == '0);
  assign stat.pay_done   = !cnt_is_cmd && !cnt_is_len &&
                           ((TOT_W'(count_r) + TOT_W'(1)) ==
                            (TOT_W'(len_r) + TOT_W'(HEADER_BYTES)));
  assign stat.idx_last   = !has_payload_r || ((TOT_W'(idx_r) + TOT_W'(1)) == TOT_W'(len_r));

  assign wr_en   = cmd.take_byte && !cnt_is_cmd && !cnt_is_len;
  assign wr_addr = ADDR_W'(count_r - CNT_W'(HEADER_BYTES));

  always_comb begin
    count_nxt = count_r;
    if (cmd.take_byte) begin
      if (cnt_is_cmd) begin
        count_nxt = CNT_W'(1);
      end else if (cnt_is_len) begin
        // An oversized or empty frame leaves nothing in the store.
        count_nxt = (oversize || stat.empty_done) ? '0 : CNT_W'(HEADER_BYTES);
      end else begin
        count_nxt = stat.pay_done ? '0 : count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && cnt_is_cmd) begin
      cmd_r <= rx_byte;
    end
    if (cmd.take_byte && cnt_is_len) begin
      len_r <= rx_byte;
    end
    if (cmd.start_replay || cmd.load_empty) begin
      idx_r         <= '0;
      has_payload_r <= cmd.start_replay;
    end else if (cmd.advance) begin
      idx_r <= idx_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= rx_byte;
    end
    if (cmd.fetch) begin
      rdata_r <= mem[idx_r];
    end
  end

  assign frame_command  = cmd_r;
  assign payload_length = has_payload_r ? len_r[FIELD_W-1:0] : '0;
  assign payload_index  = FIELD_W'(idx_r);
  assign payload_byte   = has_payload_r ? rdata_r : '0;
  assign has_payload    = has_payload_r;

endmodule

`default_nettype wire

// File: rtl/tlfd_ctrl.sv
// Controller of the deframer: receives bytes, then replays a completed frame
// one result at a time. Depends on tlfd_pkg.
`default_nettype none

module tlfd_ctrl import tlfd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_RECV: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_byte = 1'b1;
          if (stat.empty_done) begin
            cmd.load_empty = 1'b1;
            state_nxt      = ST_PRESENT;
          end else if (stat.pay_done) begin
            cmd.start_replay = 1'b1;
            state_nxt        = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_PRESENT;
      end
      ST_PRESENT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.idx_last) begin
            state_nxt = ST_RECV;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = ST_FETCH;
          end
        end
      end
      default: state_nxt = ST_RECV;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/type_length_frame_deframer.sv
// Type-length frame deframer, top level.
// Bytes are accepted while receiving; a frame is released after its last byte.
// Replay reads the store, then presents the result and holds it until it is
// taken, for each payload byte (an empty frame skips the store read);
// input is held off during replay.
// Synchronous active-low reset empties the frame in progress; store contents
// are not cleared.
`default_nettype none

`include "assert_macros.svh"

module type_length_frame_deframer import tlfd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tlfd_in_if.sink    in_ch,
  tlfd_out_if.source out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tlfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlfd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .rx_byte        (in_ch.rx_byte),
    .cmd            (cmd),
    .stat           (stat),
    .frame_command  (out_ch.frame_command),
    .payload_length (out_ch.payload_length),
    .payload_index  (out_ch.payload_index),
    .payload_byte   (out_ch.payload_byte),
    .has_payload    (out_ch.has_payload)
  );

  assign out_ch.frame_last = stat.idx_last;

  `ASSERT_ALWAYS(a_no_overlap, !(in_ch.ready && out_ch.valid), "receive overlaps replay")
  `ASSERT_IMPLIES(a_empty_single, out_ch.valid && !out_ch.has_payload, out_ch.frame_last, "empty frame result not last")
  `ASSERT_IMPLIES(a_replay_holds, out_ch.valid && out_ch.ready && !out_ch.frame_last, ##1 !in_ch.ready ##1 out_ch.valid, "replay broke off early")
  `ASSERT_IMPLIES(a_fetch_then_show, cmd.fetch, ##1 out_ch.valid, "fetched byte not presented")

endmodule

`default_nettype wire

// File: tb/tlfd_checker.sv
`timescale 1ns / 1ps
// Watches the input and result channels of the deframer, rebuilds each frame
// from the accepted bytes and compares the replayed results. Needs tlfd_pkg and tlfd_if.

module tlfd_checker import tlfd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tlfd_in_if   in_mon,
  tlfd_out_if  out_mon,
  output int   fail_count,
  output int   replay_pending
);

  typedef struct packed {
    logic [BYTE_W-1:0]  command;
    logic [FIELD_W-1:0] length;
    logic [FIELD_W-1:0] index;
    logic [BYTE_W-1:0]  data;
    logic               has_data;
    logic               last;
  } frame_result_t;

  logic [BYTE_W-1:0] frame_bytes [FRAME_STORE_BYTES];
  int unsigned       bytes_held;
  frame_result_t     frame_replay_q[$];

  // Collects one byte and queues the whole replay once the frame is complete.
  task automatic absorb_rx_byte(input logic [BYTE_W-1:0] rx);
    int unsigned   frame_total;
    int unsigned   i;
    frame_result_t res;
    if (bytes_held < FRAME_STORE_BYTES) begin
      frame_bytes[bytes_held] = rx;
      bytes_held++;
    end
    if (bytes_held < HEADER_BYTES) return;
    frame_total = frame_bytes[1] + HEADER_BYTES;
    // A header that cannot fit is dropped; the next byte starts a new frame.
    if (frame_total > FRAME_STORE_BYTES) begin
      bytes_held = 0;
      return;
    end
    if (bytes_held < frame_total) return;
    bytes_held = 0;
    res.command = frame_bytes[0];
    if (frame_bytes[1] == 0) begin
      res.length   = '0;
      res.index    = '0;
      res.data     = '0;
      res.has_data = 1'b0;
      res.last     = 1'b1;
      frame_replay_q.push_back(res);
      return;
    end
    for (i = 0; i < frame_bytes[1]; i++) begin
      res.length   = frame_bytes[1][FIELD_W-1:0];
      res.index    = FIELD_W'(i);
      res.data     = frame_bytes[HEADER_BYTES + i];
      res.has_data = 1'b1;
      res.last     = (i + 1 == frame_bytes[1]);
      frame_replay_q.push_back(res);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h",
               $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      bytes_held = 0;
      frame_replay_q.delete();
      fail_count = 0;
      replay_pending = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) absorb_rx_byte(in_mon.rx_byte);
      if (out_mon.valid && out_mon.ready) begin
        if (frame_replay_q.size() == 0) begin
          fail_count++;
          $display("%0t: result request with nothing expected, cmd 0x%02h idx %0d",
                   $time, out_mon.frame_command, out_mon.payload_index);
        end else begin
          want = frame_replay_q.pop_front();
          check_field("frame_command", want.command, out_mon.frame_command);
          check_field("payload_length", 8'(want.length), 8'(out_mon.payload_length));
          check_field("payload_index", 8'(want.index), 8'(out_mon.payload_index));
          check_field("payload_byte", want.data, out_mon.payload_byte);
          check_field("has_payload", 8'(want.has_data), 8'(out_mon.has_payload));
          check_field("frame_last", 8'(want.last), 8'(out_mon.frame_last));
        end
      end
      replay_pending = frame_replay_q.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, byte stream and result backpressure.
// Needs tlfd_pkg, tlfd_if, the deframer RTL and tlfd_checker.

module testbench;
  import tlfd_pkg::*;

  localparam int MAX_PAYLOAD  = FRAME_STORE_BYTES - HEADER_BYTES;
  localparam int RANDOM_BYTES = 110;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 2000;
  localparam int IDLE_PCT     = 14;

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   bytes_sent;
  int   fail_count;
  int   replay_pending;

  tlfd_in_if  in_ch();
  tlfd_out_if out_ch();

  type_length_frame_deframer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tlfd_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .fail_count     (fail_count),
    .replay_pending (replay_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: ready drops at random, except while idling is switched off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= idle_pct);
    end
  end

  // Ends the run when neither channel has moved a request for too long.
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("** type_length_frame_deframer: FAILED **");
    $finish;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.rx_byte = b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int unsigned len);
    int unsigned i;
    send_byte(BYTE_W'($urandom));
    send_byte(BYTE_W'(len));
    for (i = 0; i < len; i++) send_byte(BYTE_W'($urandom));
  endtask

  // Holds the stream back until every replayed result has been taken.
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (replay_pending != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned pick;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    idle_pct      = IDLE_PCT;
    bytes_sent    = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Empty frames with the lowest and highest command.
    send_byte(8'h00); send_byte(8'h00);
    send_byte(8'hFF); send_byte(8'h00);
    // A single-byte payload, then a three-byte payload, with bytes at both extremes.
    send_byte(8'hFF); send_byte(8'h01); send_byte(8'hFF);
    send_byte(8'hA5); send_byte(8'h03);
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h5A);
    // The first length that cannot fit, followed by a good frame.
    send_byte(8'h3C); send_byte(8'(MAX_PAYLOAD + 1));
    send_byte(8'h5A); send_byte(8'h02); send_byte(8'h81); send_byte(8'h7E);
    // The largest length byte, then a one-byte frame whose command and payload are zero.
    send_byte(8'hC3); send_byte(8'hFF);
    send_byte(8'h00); send_byte(8'h01); send_byte(8'h00);
    wait_drained();

    // A frame with the largest payload that the size limit allows.
    send_frame(MAX_PAYLOAD);
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      idle_pct = (bytes_sent >= 30 && bytes_sent < 90) ? 0 : IDLE_PCT;
      pick = $urandom_range(99);
      if (pick < 3) begin
        wait_drained();
        send_frame($urandom_range(10));
      end else if (pick < 11) begin
        send_byte(BYTE_W'($urandom));
        send_byte(BYTE_W'($urandom_range(255, MAX_PAYLOAD + 1)));
      end else if (pick < 13) begin
        send_frame($urandom_range(MAX_PAYLOAD, MAX_PAYLOAD - 4));
      end else if (pick < 20) begin
        send_frame(0);
      end else begin
        send_frame($urandom_range(10, 1));
      end
    end
    in_ch.valid = 1'b0;
    idle_pct    = IDLE_PCT;

    while (replay_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("** type_length_frame_deframer: PASSED **");
    else
      $display("** type_length_frame_deframer: FAILED **");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tlfd_pkg.sv
rtl/tlfd_if.sv
rtl/tlfd_dp.sv
rtl/tlfd_ctrl.sv
rtl/type_length_frame_deframer.sv
tb/tlfd_checker.sv
tb/testbench.sv
